>>> rtl/dsb_pkg.sv
package dsb_pkg;

   // deck geometry
   localparam int DECK_SIZE     = 52;
   localparam int RANK_COUNT    = 13;
   localparam int BITS_PER_DRAW = 6;

   // generator modulus, product of two primes
   localparam int BBS_PRIME_P = 43;
   localparam int BBS_PRIME_Q = 47;
   localparam int GEN_MODULUS = BBS_PRIME_P * BBS_PRIME_Q;

   // field widths fixed by the ports
   localparam int SEED_W       = 12;
   localparam int RANK_W       = 4;
   localparam int DECK_INDEX_W = 6;

   // generator datapath widths
   localparam int GEN_W     = SEED_W;
   localparam int PROD_W    = 2 * GEN_W;
   localparam int GEN_RECIP = (2 ** PROD_W) / GEN_MODULUS;
   localparam int Q_W       = $clog2(GEN_RECIP + 1);

   // deck counters
   localparam int IDX_W = $clog2(DECK_SIZE);
   localparam int DEALT = (DECK_SIZE / 2) * 2;
   localparam int BIT_W = $clog2(BITS_PER_DRAW + 1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FILL,
      ST_DRAW,
      ST_RD_I,
      ST_RD_J,
      ST_WR_I,
      ST_WR_J,
      ST_DEAL
   } state_type;

   // request into the squaring unit
   typedef struct packed {
      logic             start;
      logic [GEN_W-1:0] x;
   } sq_req_type;

   // response from the squaring unit
   typedef struct packed {
      logic             done;
      logic [GEN_W-1:0] value;
      logic             parity;
   } sq_rsp_type;

endpackage

>>> rtl/dsb_sqmod.sv
module dsb_sqmod (
   input  logic                clock,
   input  logic                reset,
   input  dsb_pkg::sq_req_type sq_req,
   output dsb_pkg::sq_rsp_type sq_rsp
);

   localparam int MUL_W = dsb_pkg::PROD_W + dsb_pkg::Q_W;

   logic [3:0]                  valid_ff;
   logic [3:0]                  valid_in;
   logic [dsb_pkg::PROD_W-1:0]  p1_ff;
   logic [dsb_pkg::PROD_W-1:0]  p1_in;
   logic [dsb_pkg::PROD_W-1:0]  p2_ff;
   logic [dsb_pkg::Q_W-1:0]     q_ff;
   logic [dsb_pkg::Q_W-1:0]     q_in;
   logic [dsb_pkg::GEN_W-1:0]   r3_ff;
   logic [dsb_pkg::GEN_W-1:0]   r3_in;
   logic [dsb_pkg::GEN_W-1:0]   res_ff;
   logic [dsb_pkg::GEN_W-1:0]   res_in;
   logic                        par_ff;
   logic [MUL_W-1:0]            recip_prod;
   logic [dsb_pkg::PROD_W-1:0]  qm;
   logic [dsb_pkg::PROD_W-1:0]  diff;

   // stage 1: square
   assign p1_in = dsb_pkg::PROD_W'(sq_req.x) * dsb_pkg::PROD_W'(sq_req.x);

   // stage 2: quotient estimate by reciprocal, never above the true quotient
   assign recip_prod = MUL_W'(p1_ff) * MUL_W'(dsb_pkg::GEN_RECIP);
   assign q_in       = recip_prod[dsb_pkg::PROD_W +: dsb_pkg::Q_W];

   // stage 3: remainder estimate, below twice the modulus
   assign qm    = dsb_pkg::PROD_W'(q_ff) * dsb_pkg::PROD_W'(dsb_pkg::GEN_MODULUS);
   assign diff  = p2_ff - qm;
   assign r3_in = diff[dsb_pkg::GEN_W-1:0];

   // stage 4: final correction
   always_comb begin
      if (r3_ff >= dsb_pkg::GEN_W'(dsb_pkg::GEN_MODULUS)) begin
         res_in = r3_ff - dsb_pkg::GEN_W'(dsb_pkg::GEN_MODULUS);
      end else begin
         res_in = r3_ff;
      end
   end

   assign valid_in = {valid_ff[2:0], sq_req.start};

   // stage valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // stage payload
   always_ff @(posedge clock) begin
      p1_ff  <= p1_in;
      p2_ff  <= p1_ff;
      q_ff   <= q_in;
      r3_ff  <= r3_in;
      res_ff <= res_in;
      par_ff <= ^res_in;
   end

   assign sq_rsp.done   = valid_ff[3];
   assign sq_rsp.value  = res_ff;
   assign sq_rsp.parity = par_ff;

   a_res_reduced : assert property (@(posedge clock) disable iff (reset)
      sq_rsp.done |-> (res_ff < dsb_pkg::GEN_W'(dsb_pkg::GEN_MODULUS)))
      else $error("squaring result not reduced");

   a_one_in_flight : assert property (@(posedge clock) disable iff (reset)
      $onehot0(valid_ff))
      else $error("more than one squaring in flight");

   a_done_single : assert property (@(posedge clock) disable iff (reset)
      sq_rsp.done |=> !sq_rsp.done)
      else $error("squaring done held for two cycles");

endmodule

>>> rtl/deck_shuffle_bbs_unit.sv
// deck shuffler with a blum blum shub generator
// a transfer on the request side is start high while busy is low; req_seed
// is taken then. the block fills its deck memory with ranks 1..13 repeating,
// shuffles it fisher-yates from the top slot down and deals the deck in order.
// each dealt card is one transfer on the response side: rsp_valid high for a
// single cycle with rank, pile (alternating 0/1), deck position and a last flag.
// sequence: fill writes each of the DECK_SIZE slots once; each of the
// DECK_SIZE-1 swaps runs BITS_PER_DRAW squarings through the four-stage
// square-and-reduce pipeline, then a memory read, read, write and write;
// the deal issues one read per cycle, each card appearing in the cycle after
// its read. busy covers fill, shuffle and deal, the final card strobing in
// the cycle after busy falls. the deck memory has one write and one
// registered read port, so each swap reads and writes in separate steps.
// the receiver cannot stall, so cards leave at one per cycle with no
// buffering. reset returns the controller to idle and drops busy and
// rsp_valid; deck memory contents are not cleared, every deal rewrites it.
module deck_shuffle_bbs_unit (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic [dsb_pkg::SEED_W-1:0]        req_seed,
   output logic                              rsp_valid,
   output logic [dsb_pkg::RANK_W-1:0]        rsp_card_rank,
   output logic                              rsp_pile,
   output logic [dsb_pkg::DECK_INDEX_W-1:0]  rsp_deck_index,
   output logic                              rsp_last
);

   localparam int IDX_W = dsb_pkg::IDX_W;

   dsb_pkg::state_type          state_ff;
   dsb_pkg::state_type          state_in;
   logic [dsb_pkg::GEN_W-1:0]   x_ff;
   logic [dsb_pkg::GEN_W-1:0]   x_in;
   logic [IDX_W-1:0]            pos_ff;
   logic [IDX_W-1:0]            pos_in;
   logic [IDX_W-1:0]            rem_ff;
   logic [IDX_W-1:0]            rem_in;
   logic [dsb_pkg::BIT_W-1:0]   bit_cnt_ff;
   logic [dsb_pkg::BIT_W-1:0]   bit_cnt_in;
   logic [IDX_W-1:0]            idx_ff;
   logic [IDX_W-1:0]            idx_in;
   logic [dsb_pkg::RANK_W-1:0]  rank_ff;
   logic [dsb_pkg::RANK_W-1:0]  rank_in;
   logic [dsb_pkg::RANK_W-1:0]  tmp_ff;
   logic [dsb_pkg::RANK_W-1:0]  tmp_in;
   logic                        out_valid_ff;
   logic                        out_valid_in;
   logic [IDX_W-1:0]            out_idx_ff;
   logic [IDX_W-1:0]            out_idx_in;

   logic [dsb_pkg::RANK_W-1:0]  deck_mem_ff [dsb_pkg::DECK_SIZE];
   logic [dsb_pkg::RANK_W-1:0]  rd_data_ff;
   logic                        mem_we;
   logic [IDX_W-1:0]            mem_waddr;
   logic [dsb_pkg::RANK_W-1:0]  mem_wdata;
   logic [IDX_W-1:0]            mem_raddr;

   dsb_pkg::sq_req_type         sq_req;
   dsb_pkg::sq_rsp_type         sq_rsp;

   logic                        fill_end;
   logic                        draw_end;
   logic                        shuffle_end;
   logic                        deal_end;
   logic [IDX_W:0]              rem_shift;
   logic [IDX_W:0]              modulus;
   logic [IDX_W-1:0]            rem_next;

   dsb_sqmod u_sqmod (
      .clock  (clock),
      .reset  (reset),
      .sq_req (sq_req),
      .sq_rsp (sq_rsp)
   );

   assign fill_end    = (idx_ff == IDX_W'(dsb_pkg::DECK_SIZE - 1));
   assign draw_end    = sq_rsp.done && (bit_cnt_ff == dsb_pkg::BIT_W'(dsb_pkg::BITS_PER_DRAW - 1));
   assign shuffle_end = (pos_ff == IDX_W'(1));
   assign deal_end    = (idx_ff == IDX_W'(dsb_pkg::DEALT - 1));

   // running remainder of the draw modulo pos+1, one draw bit at a time
   assign rem_shift = {rem_ff, sq_rsp.parity};
   assign modulus   = (IDX_W + 1)'(pos_ff) + (IDX_W + 1)'(1);
   always_comb begin
      if (rem_shift >= modulus) begin
         rem_next = IDX_W'(rem_shift - modulus);
      end else begin
         rem_next = IDX_W'(rem_shift);
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         dsb_pkg::ST_IDLE: if (start) state_in = dsb_pkg::ST_FILL;
         dsb_pkg::ST_FILL: if (fill_end) state_in = dsb_pkg::ST_DRAW;
         dsb_pkg::ST_DRAW: if (draw_end) state_in = dsb_pkg::ST_RD_I;
         dsb_pkg::ST_RD_I: state_in = dsb_pkg::ST_RD_J;
         dsb_pkg::ST_RD_J: state_in = dsb_pkg::ST_WR_I;
         dsb_pkg::ST_WR_I: state_in = dsb_pkg::ST_WR_J;
         dsb_pkg::ST_WR_J: begin
            if (shuffle_end) state_in = dsb_pkg::ST_DEAL;
            else state_in = dsb_pkg::ST_DRAW;
         end
         dsb_pkg::ST_DEAL: if (deal_end) state_in = dsb_pkg::ST_IDLE;
         default: state_in = dsb_pkg::ST_IDLE;
      endcase
   end

   // outputs of the controller: memory port, squaring launch, busy
   always_comb begin
      busy      = (state_ff != dsb_pkg::ST_IDLE);
      mem_we    = 1'b0;
      mem_waddr = idx_ff;
      mem_wdata = rank_ff;
      mem_raddr = idx_ff;
      sq_req.start = 1'b0;
      sq_req.x     = sq_rsp.done ? sq_rsp.value : x_ff;
      unique case (state_ff)
         dsb_pkg::ST_IDLE: ;
         dsb_pkg::ST_FILL: begin
            mem_we       = 1'b1;
            sq_req.start = fill_end;
         end
         dsb_pkg::ST_DRAW: sq_req.start = sq_rsp.done && !draw_end;
         dsb_pkg::ST_RD_I: mem_raddr = pos_ff;
         dsb_pkg::ST_RD_J: mem_raddr = rem_ff;
         dsb_pkg::ST_WR_I: begin
            mem_we    = 1'b1;
            mem_waddr = pos_ff;
            mem_wdata = rd_data_ff;
         end
         dsb_pkg::ST_WR_J: begin
            mem_we       = 1'b1;
            mem_waddr    = rem_ff;
            mem_wdata    = tmp_ff;
            sq_req.start = !shuffle_end;
         end
         dsb_pkg::ST_DEAL: ;
         default: ;
      endcase
   end

   // datapath next values
   always_comb begin
      x_in         = x_ff;
      pos_in       = pos_ff;
      rem_in       = rem_ff;
      bit_cnt_in   = bit_cnt_ff;
      idx_in       = idx_ff;
      rank_in      = rank_ff;
      tmp_in       = tmp_ff;
      out_valid_in = 1'b0;
      out_idx_in   = out_idx_ff;
      unique case (state_ff)
         dsb_pkg::ST_IDLE: begin
            if (start) begin
               x_in    = req_seed;
               idx_in  = '0;
               rank_in = dsb_pkg::RANK_W'(1);
            end
         end
         dsb_pkg::ST_FILL: begin
            idx_in = idx_ff + IDX_W'(1);
            if (rank_ff == dsb_pkg::RANK_W'(dsb_pkg::RANK_COUNT)) begin
               rank_in = dsb_pkg::RANK_W'(1);
            end else begin
               rank_in = rank_ff + dsb_pkg::RANK_W'(1);
            end
            if (fill_end) begin
               pos_in     = IDX_W'(dsb_pkg::DECK_SIZE - 1);
               rem_in     = '0;
               bit_cnt_in = '0;
            end
         end
         dsb_pkg::ST_DRAW: begin
            if (sq_rsp.done) begin
               x_in       = sq_rsp.value;
               rem_in     = rem_next;
               bit_cnt_in = bit_cnt_ff + dsb_pkg::BIT_W'(1);
            end
         end
         dsb_pkg::ST_RD_I: ;
         dsb_pkg::ST_RD_J: tmp_in = rd_data_ff;
         dsb_pkg::ST_WR_I: ;
         dsb_pkg::ST_WR_J: begin
            if (shuffle_end) begin
               pos_in = '0;
               idx_in = '0;
            end else begin
               pos_in     = pos_ff - IDX_W'(1);
               rem_in     = '0;
               bit_cnt_in = '0;
            end
         end
         dsb_pkg::ST_DEAL: begin
            idx_in       = idx_ff + IDX_W'(1);
            out_valid_in = 1'b1;
            out_idx_in   = idx_ff;
         end
         default: ;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= dsb_pkg::ST_IDLE;
         x_ff         <= '0;
         pos_ff       <= '0;
         rem_ff       <= '0;
         bit_cnt_ff   <= '0;
         idx_ff       <= '0;
         rank_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         x_ff         <= x_in;
         pos_ff       <= pos_in;
         rem_ff       <= rem_in;
         bit_cnt_ff   <= bit_cnt_in;
         idx_ff       <= idx_in;
         rank_ff      <= rank_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      tmp_ff     <= tmp_in;
      out_idx_ff <= out_idx_in;
   end

   // deck memory, one write port and one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         deck_mem_ff[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= deck_mem_ff[mem_raddr];
   end

   // result port
   assign rsp_valid      = out_valid_ff;
   assign rsp_card_rank  = rd_data_ff;
   assign rsp_pile       = out_idx_ff[0];
   assign rsp_deck_index = dsb_pkg::DECK_INDEX_W'(out_idx_ff);
   assign rsp_last       = out_valid_ff && (out_idx_ff == IDX_W'(dsb_pkg::DEALT - 1));

   a_start_fills : assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (state_ff == dsb_pkg::ST_FILL))
      else $error("accepted request did not start the fill");

   a_rsp_from_deal : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(state_ff == dsb_pkg::ST_DEAL))
      else $error("card strobed outside the deal");

   a_swap_index : assert property (@(posedge clock) disable iff (reset)
      (state_ff == dsb_pkg::ST_RD_I) |-> (rem_ff <= pos_ff))
      else $error("swap index above shuffle position");

   a_write_range : assert property (@(posedge clock) disable iff (reset)
      mem_we |-> (mem_waddr < IDX_W'(dsb_pkg::DECK_SIZE - 1) ||
                  mem_waddr == IDX_W'(dsb_pkg::DECK_SIZE - 1)))
      else $error("deck write beyond the deck");

   a_idle_quiet : assert property (@(posedge clock) disable iff (reset)
      (state_ff == dsb_pkg::ST_IDLE) |-> !sq_rsp.done)
      else $error("squaring active while idle");

endmodule

>>> tb/tb.sv
module tb;

   // how the expected deal of a directed row is obtained
   typedef enum logic {
      DEAL_PREDICTED,
      DEAL_ROTATED
   } deal_kind_type;

   typedef struct packed {
      logic [dsb_pkg::SEED_W-1:0] seed;
      deal_kind_type              kind;
   } seed_row_type;

   typedef struct packed {
      logic [dsb_pkg::RANK_W-1:0]       rank;
      logic                             pile;
      logic [dsb_pkg::DECK_INDEX_W-1:0] deck_index;
      logic                             last;
   } dealt_card_type;

   localparam int RANDOM_DEALS = 297;

   // directed seeds; a seed that is a multiple of the modulus squares to zero,
   // so every draw is zero and each swap is with slot 0: the deck comes out
   // rotated by one slot
   localparam seed_row_type DIRECTED_SEEDS [13] = '{
      '{12'd0,    DEAL_ROTATED},
      '{12'd2021, DEAL_ROTATED},
      '{12'd4042, DEAL_ROTATED},
      '{12'd1,    DEAL_PREDICTED},
      '{12'd2,    DEAL_PREDICTED},
      '{12'd2020, DEAL_PREDICTED},
      '{12'd2022, DEAL_PREDICTED},
      '{12'd4095, DEAL_PREDICTED},
      '{12'd43,   DEAL_PREDICTED},
      '{12'd47,   DEAL_PREDICTED},
      '{12'h800,  DEAL_PREDICTED},
      '{12'h555,  DEAL_PREDICTED},
      '{12'haaa,  DEAL_PREDICTED}
   };

   logic                             clock = 1'b0;
   logic                             reset = 1'b1;
   logic                             start = 1'b0;
   logic [dsb_pkg::SEED_W-1:0]       req_seed = '0;
   logic                             busy;
   logic                             rsp_valid;
   logic [dsb_pkg::RANK_W-1:0]       rsp_card_rank;
   logic                             rsp_pile;
   logic [dsb_pkg::DECK_INDEX_W-1:0] rsp_deck_index;
   logic                             rsp_last;

   dealt_card_type cards_due [$];
   int             mismatch_count = 0;
   bit             no_idle = 1'b0;

   deck_shuffle_bbs_unit DUT (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_seed       (req_seed),
      .rsp_valid      (rsp_valid),
      .rsp_card_rank  (rsp_card_rank),
      .rsp_pile       (rsp_pile),
      .rsp_deck_index (rsp_deck_index),
      .rsp_last       (rsp_last)
   );

   // clock, period 10
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   task automatic flag_mismatch(input string what);
      $display("mismatch at %0t: %s", $time, what);
      mismatch_count++;
   endtask

   // fill, fisher-yates shuffle with blum blum shub draws, then queue the deal
   function automatic void shuffle_deck(input logic [dsb_pkg::SEED_W-1:0] seed);
      logic [dsb_pkg::RANK_W-1:0] slot [dsb_pkg::DECK_SIZE];
      logic [dsb_pkg::GEN_W-1:0]  gen;
      logic [15:0]                draw;
      int unsigned                j;
      logic [dsb_pkg::RANK_W-1:0] held;
      dealt_card_type             card;
      gen = seed;
      for (int i = 0; i < dsb_pkg::DECK_SIZE; i++) begin
         slot[i] = dsb_pkg::RANK_W'((i % dsb_pkg::RANK_COUNT) + 1);
      end
      for (int i = dsb_pkg::DECK_SIZE - 1; i > 0; i--) begin
         draw = '0;
         for (int b = 0; b < dsb_pkg::BITS_PER_DRAW; b++) begin
            gen  = dsb_pkg::GEN_W'((gen * gen) % dsb_pkg::GEN_MODULUS);
            draw = {draw[14:0], ^gen};
         end
         j       = draw % (i + 1);
         held    = slot[i];
         slot[i] = slot[j];
         slot[j] = held;
      end
      for (int i = 0; i < dsb_pkg::DEALT; i++) begin
         card.rank       = slot[i];
         card.pile       = i[0];
         card.deck_index = dsb_pkg::DECK_INDEX_W'(i);
         card.last       = (i == dsb_pkg::DEALT - 1);
         cards_due.push_back(card);
      end
   endfunction

   // offer one seed until the block takes it, idling at random, then queue its deal
   task automatic deal_seed(input logic [dsb_pkg::SEED_W-1:0] seed,
                            input deal_kind_type kind);
      bit             taken;
      dealt_card_type card;
      taken = 1'b0;
      req_seed <= seed;
      while (!taken) begin
         start <= (no_idle || $urandom_range(0, 99) >= 8);
         @(posedge clock);
         taken = start && !busy;
      end
      if (kind == DEAL_ROTATED) begin
         for (int i = 0; i < dsb_pkg::DEALT; i++) begin
            card.rank       = dsb_pkg::RANK_W'((((i + 1) % dsb_pkg::DECK_SIZE)
                                                % dsb_pkg::RANK_COUNT) + 1);
            card.pile       = i[0];
            card.deck_index = dsb_pkg::DECK_INDEX_W'(i);
            card.last       = (i == dsb_pkg::DEALT - 1);
            cards_due.push_back(card);
         end
      end else begin
         shuffle_deck(seed);
      end
   endtask

   // compare every dealt card against the oldest outstanding one
   always @(posedge clock) begin
      dealt_card_type want;
      if (!reset && rsp_valid) begin
         if (cards_due.size() == 0) begin
            flag_mismatch($sformatf("card with nothing outstanding, index %0d",
                                    rsp_deck_index));
         end else begin
            want = cards_due.pop_front();
            if (rsp_card_rank !== want.rank)
               flag_mismatch($sformatf("card_rank %0d, wanted %0d at index %0d",
                                       rsp_card_rank, want.rank, want.deck_index));
            if (rsp_pile !== want.pile)
               flag_mismatch($sformatf("pile %0b, wanted %0b at index %0d",
                                       rsp_pile, want.pile, want.deck_index));
            if (rsp_deck_index !== want.deck_index)
               flag_mismatch($sformatf("deck_index %0d, wanted %0d",
                                       rsp_deck_index, want.deck_index));
            if (rsp_last !== want.last)
               flag_mismatch($sformatf("last %0b, wanted %0b at index %0d",
                                       rsp_last, want.last, want.deck_index));
         end
      end
   end

   // stimulus
   initial begin
      logic [dsb_pkg::SEED_W-1:0] seed;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed seeds
      foreach (DIRECTED_SEEDS[k]) begin
         deal_seed(DIRECTED_SEEDS[k].seed, DIRECTED_SEEDS[k].kind);
      end

      // random seeds, mostly coprime to the modulus
      for (int n = 0; n < RANDOM_DEALS; n++) begin
         no_idle = (n >= 120 && n < 200);
         if ($urandom_range(0, 99) < 85) begin
            do begin
               seed = dsb_pkg::SEED_W'($urandom_range(0, 4095));
            end while (seed % dsb_pkg::BBS_PRIME_P == 0 ||
                       seed % dsb_pkg::BBS_PRIME_Q == 0);
         end else begin
            seed = dsb_pkg::SEED_W'($urandom_range(0, 4095));
         end
         deal_seed(seed, DEAL_PREDICTED);
      end
      start <= 1'b0;

      // drain the last deal, then idle before reporting the status
      while (cards_due.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   // run limit
   initial begin
      #30000000;
      $display("status: fail");
      $finish;
   end

endmodule

>>> sim.f
rtl/dsb_pkg.sv
rtl/dsb_sqmod.sv
rtl/deck_shuffle_bbs_unit.sv
tb/tb.sv
